[design/multi_pattern_byte_matcher_macros.svh]
// Assertion macros for the multi-pattern byte matcher.
`ifndef MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH
`define MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked every cycle out of reset.
`define MPBM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mpbm: assertion failed");

// Condition in one cycle requires a condition in the next.
`define MPBM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("mpbm: assertion failed");

`else

`define MPBM_ASSERT(label, prop)
`define MPBM_ASSERT_NEXT(label, pre, post)

`endif

`endif

[design/mpbm_pkg.sv]
`default_nettype none

package mpbm_pkg;

    localparam int MAX_NODES         = 4096;
    localparam int NODE_W            = $clog2(MAX_NODES);
    localparam int MAX_PATTERN_COUNT = 4096;
    localparam int PAT_W             = $clog2(MAX_PATTERN_COUNT);
    localparam int MAX_PATTERN_LEN   = 64;
    localparam int LEN_W             = $clog2(MAX_PATTERN_LEN + 1);
    localparam int COUNT_WIDTH       = 32;
    localparam int SYM_W             = 8;
    localparam int CHILD_AW          = NODE_W + SYM_W;
    localparam int RESULT_CAP        = 64;
    localparam int RES_W             = $clog2(RESULT_CAP + 1);
    localparam int ID_W              = 12;
    localparam int OUT_W             = 32;
    localparam int OP_W              = 3;
    localparam int IN_TDATA_W        = 24;
    localparam int OUT_BITS          = ID_W + 1 + OUT_W + OUT_W + 1 + 3;
    localparam int OUT_TDATA_W       = 88;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_BUILD  = 3'd2,
        OP_SCAN   = 3'd3,
        OP_END    = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        KIND_MATCH   = 3'd0,
        KIND_VERDICT = 3'd1,
        KIND_READ    = 3'd2,
        KIND_ACK     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NODES    = 3'd1,
        ERR_PATTERNS = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_PHASE    = 3'd4
    } err_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_INS_CK, ST_RD_OUT, ST_SWEEP,
        ST_BR_RD, ST_BR_CK, ST_B_POP, ST_B_U, ST_B_UF, ST_BV_RD, ST_BV_CK,
        ST_BF_RD, ST_BF_CK, ST_BF_NX, ST_B_G, ST_B_VW,
        ST_SC_RD, ST_SC_CK, ST_SC_NX, ST_T_CHK, ST_T_ND, ST_T_CNT, ST_S_FIN
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] fail;
        logic              pvalid;
        logic [PAT_W-1:0]  pid;
        logic              term;
    } node_t;

    typedef struct packed {
        kind_t            kind;
        logic [ID_W-1:0]  pid;
        logic             first;
        logic [OUT_W-1:0] hit;
        logic [OUT_W-1:0] total;
        logic             inf;
        err_t             err;
        logic             last;
    } res_t;

    typedef struct packed {
        logic ready;
        logic clearing;
    } ctrl_stat_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [ID_W-1:0] id,
                                    input logic first, input logic [OUT_W-1:0] hit,
                                    input logic [OUT_W-1:0] tot, input logic inf,
                                    input err_t e);
        res_t r;
        r.kind  = k;
        r.pid   = id;
        r.first = first;
        r.hit   = hit;
        r.total = tot;
        r.inf   = inf;
        r.err   = e;
        r.last  = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/mpbm_ram.sv]
`default_nettype none

module mpbm_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem_array [2**AW];
    logic [DW-1:0] rd_data_reg;

    // read-before-write; data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/mpbm_ctrl.sv]
`default_nettype none

module mpbm_ctrl
    import mpbm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [OP_W-1:0]  in_op,
    input  wire logic [SYM_W-1:0] in_byte,
    input  wire logic [ID_W-1:0]  in_idx,
    input  wire logic             out_free,
    output logic                  emit,
    output res_t                  res,
    output ctrl_stat_t            stat
);

    // memories
    logic                  c_wr_en, c_rd_en;
    logic [CHILD_AW-1:0]   c_wr_addr, c_rd_addr;
    logic [NODE_W-1:0]     c_wr_data, c_rd_data;
    logic                  n_wr_en, n_rd_en;
    logic [NODE_W-1:0]     n_wr_addr, n_rd_addr;
    node_t                 n_wr_data, n_rd_data;
    logic                  q_wr_en, q_rd_en;
    logic [NODE_W-1:0]     q_wr_addr, q_rd_addr;
    logic [NODE_W-1:0]     q_wr_data, q_rd_data;
    logic                  k_wr_en, k_rd_en;
    logic [PAT_W-1:0]      k_wr_addr, k_rd_addr;
    logic [COUNT_WIDTH-1:0] k_wr_data, k_rd_data;
    logic                  f_wr_en, f_rd_en;
    logic [PAT_W-1:0]      f_wr_addr, f_rd_addr;
    logic [0:0]            f_wr_data, f_rd_data;

    mpbm_ram #(.AW(CHILD_AW), .DW(NODE_W)) u_child (
        .aclk(aclk), .wr_en(c_wr_en), .wr_addr(c_wr_addr), .wr_data(c_wr_data),
        .rd_en(c_rd_en), .rd_addr(c_rd_addr), .rd_data(c_rd_data));

    mpbm_ram #(.AW(NODE_W), .DW($bits(node_t))) u_node (
        .aclk(aclk), .wr_en(n_wr_en), .wr_addr(n_wr_addr), .wr_data(n_wr_data),
        .rd_en(n_rd_en), .rd_addr(n_rd_addr), .rd_data(n_rd_data));

    mpbm_ram #(.AW(NODE_W), .DW(NODE_W)) u_queue (
        .aclk(aclk), .wr_en(q_wr_en), .wr_addr(q_wr_addr), .wr_data(q_wr_data),
        .rd_en(q_rd_en), .rd_addr(q_rd_addr), .rd_data(q_rd_data));

    mpbm_ram #(.AW(PAT_W), .DW(COUNT_WIDTH)) u_count (
        .aclk(aclk), .wr_en(k_wr_en), .wr_addr(k_wr_addr), .wr_data(k_wr_data),
        .rd_en(k_rd_en), .rd_addr(k_rd_addr), .rd_data(k_rd_data));

    mpbm_ram #(.AW(PAT_W), .DW(1)) u_found (
        .aclk(aclk), .wr_en(f_wr_en), .wr_addr(f_wr_addr), .wr_data(f_wr_data),
        .rd_en(f_rd_en), .rd_addr(f_rd_addr), .rd_data(f_rd_data));

    // registers
    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [SYM_W-1:0]       byte_reg, byte_next;
    logic [ID_W-1:0]        idx_reg, idx_next;
    logic [NODE_W:0]        node_used_reg, node_used_next;
    logic [PAT_W:0]         pat_used_reg, pat_used_next;
    logic [NODE_W-1:0]      ins_node_reg, ins_node_next;
    logic [LEN_W-1:0]       ins_len_reg, ins_len_next;
    logic [NODE_W-1:0]      scan_node_reg, scan_node_next;
    logic [COUNT_WIDTH-1:0] stream_reg, stream_next;
    logic                   any_found_reg, any_found_next;
    logic                   built_reg, built_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic [NODE_W-1:0]      head_reg, head_next;
    logic [NODE_W-1:0]      tail_reg, tail_next;
    logic [NODE_W-1:0]      u_reg, u_next;
    logic [NODE_W-1:0]      fu_reg, fu_next;
    logic [NODE_W-1:0]      v_reg, v_next;
    logic [NODE_W-1:0]      f_reg, f_next;
    logic [NODE_W-1:0]      g_reg, g_next;
    logic                   tg_reg, tg_next;
    logic [NODE_W-1:0]      cur_reg, cur_next;
    logic [NODE_W-1:0]      nfail_reg, nfail_next;
    logic [PAT_W-1:0]       id_reg, id_next;
    logic [RES_W-1:0]       n_reg, n_next;
    logic                   pend_valid_reg, pend_valid_next;
    res_t                   pend_reg, pend_next;
    logic [CHILD_AW-1:0]    clr_reg, clr_next;

    err_t                   dec_err;
    logic                   idx_ok;
    logic                   walk_on;
    logic [COUNT_WIDTH-1:0] hit_new;
    logic [NODE_W-1:0]      scan_hit;

    assign idx_ok   = (int'(idx_reg) < MAX_PATTERN_COUNT);
    assign walk_on  = (cur_reg != '0) && (c_rd_data == '0);
    assign hit_new  = sat_inc(k_rd_data);
    assign scan_hit = (c_rd_data != '0) ? c_rd_data : cur_reg;

    always_comb begin
        dec_err = ERR_NONE;
        case (op_reg)
            OP_APPEND: begin
                if (built_reg) begin
                    dec_err = ERR_PHASE;
                end else if (ins_len_reg >= LEN_W'(MAX_PATTERN_LEN)) begin
                    dec_err = ERR_LENGTH;
                end
            end
            OP_CLOSE: begin
                if (built_reg) begin
                    dec_err = ERR_PHASE;
                end else if (ins_len_reg != '0 &&
                             pat_used_reg >= (PAT_W+1)'(MAX_PATTERN_COUNT)) begin
                    dec_err = ERR_PATTERNS;
                end
            end
            OP_BUILD: begin
                if (built_reg || ins_len_reg != '0) begin
                    dec_err = ERR_PHASE;
                end
            end
            OP_SCAN, OP_END: begin
                if (!built_reg) begin
                    dec_err = ERR_PHASE;
                end
            end
            OP_READ: begin
                dec_err = ERR_NONE;
            end
            default: begin
                dec_err = ERR_PHASE;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  state_next = (&clr_reg) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:   state_next = in_accept ? ST_DECODE : ST_IDLE;
            ST_DECODE: begin
                if (dec_err != ERR_NONE) begin
                    state_next = out_free ? ST_IDLE : ST_DECODE;
                end else begin
                    case (op_reg)
                        OP_APPEND: state_next = ST_INS_CK;
                        OP_BUILD:  state_next = ST_BR_RD;
                        OP_SCAN:   state_next = ST_SC_RD;
                        OP_END:    state_next = out_free ? ST_SWEEP : ST_DECODE;
                        OP_READ: begin
                            if (idx_ok) begin
                                state_next = ST_RD_OUT;
                            end else begin
                                state_next = out_free ? ST_IDLE : ST_DECODE;
                            end
                        end
                        default:   state_next = out_free ? ST_IDLE : ST_DECODE;
                    endcase
                end
            end
            ST_INS_CK: state_next = out_free ? ST_IDLE : ST_INS_CK;
            ST_RD_OUT: state_next = out_free ? ST_IDLE : ST_RD_OUT;
            ST_SWEEP:  state_next = (&clr_reg[PAT_W-1:0]) ? ST_IDLE : ST_SWEEP;
            ST_BR_RD:  state_next = ST_BR_CK;
            ST_BR_CK:  state_next = (&sym_reg) ? ST_B_POP : ST_BR_RD;
            ST_B_POP: begin
                if (head_reg != tail_reg) begin
                    state_next = ST_B_U;
                end else begin
                    state_next = out_free ? ST_IDLE : ST_B_POP;
                end
            end
            ST_B_U:    state_next = ST_B_UF;
            ST_B_UF:   state_next = ST_BV_RD;
            ST_BV_RD:  state_next = ST_BV_CK;
            ST_BV_CK: begin
                if (c_rd_data != '0) begin
                    state_next = ST_BF_RD;
                end else begin
                    state_next = (&sym_reg) ? ST_B_POP : ST_BV_RD;
                end
            end
            ST_BF_RD:  state_next = ST_BF_CK;
            ST_BF_CK:  state_next = ((f_reg != '0) && (c_rd_data == '0)) ? ST_BF_NX : ST_B_G;
            ST_BF_NX:  state_next = ST_BF_RD;
            ST_B_G:    state_next = ST_B_VW;
            ST_B_VW:   state_next = (&sym_reg) ? ST_B_POP : ST_BV_RD;
            ST_SC_RD:  state_next = ST_SC_CK;
            ST_SC_CK:  state_next = walk_on ? ST_SC_NX : ST_T_CHK;
            ST_SC_NX:  state_next = ST_SC_RD;
            ST_T_CHK: begin
                if (cur_reg == '0 || n_reg >= RES_W'(RESULT_CAP)) begin
                    state_next = ST_S_FIN;
                end else begin
                    state_next = ST_T_ND;
                end
            end
            ST_T_ND: begin
                if (!n_rd_data.term) begin
                    state_next = ST_S_FIN;
                end else if (n_rd_data.pvalid) begin
                    state_next = ST_T_CNT;
                end else begin
                    state_next = ST_T_CHK;
                end
            end
            ST_T_CNT:  state_next = (pend_valid_reg && !out_free) ? ST_T_CNT : ST_T_CHK;
            ST_S_FIN:  state_next = (pend_valid_reg && !out_free) ? ST_S_FIN : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        op_next         = op_reg;
        byte_next       = byte_reg;
        idx_next        = idx_reg;
        node_used_next  = node_used_reg;
        pat_used_next   = pat_used_reg;
        ins_node_next   = ins_node_reg;
        ins_len_next    = ins_len_reg;
        scan_node_next  = scan_node_reg;
        stream_next     = stream_reg;
        any_found_next  = any_found_reg;
        built_next      = built_reg;
        sym_next        = sym_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        u_next          = u_reg;
        fu_next         = fu_reg;
        v_next          = v_reg;
        f_next          = f_reg;
        g_next          = g_reg;
        tg_next         = tg_reg;
        cur_next        = cur_reg;
        nfail_next      = nfail_reg;
        id_next         = id_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        clr_next        = clr_reg;

        c_wr_en = 1'b0; c_wr_addr = '0; c_wr_data = '0;
        c_rd_en = 1'b0; c_rd_addr = '0;
        n_wr_en = 1'b0; n_wr_addr = '0; n_wr_data = '0;
        n_rd_en = 1'b0; n_rd_addr = '0;
        q_wr_en = 1'b0; q_wr_addr = '0; q_wr_data = '0;
        q_rd_en = 1'b0; q_rd_addr = '0;
        k_wr_en = 1'b0; k_wr_addr = '0; k_wr_data = '0;
        k_rd_en = 1'b0; k_rd_addr = '0;
        f_wr_en = 1'b0; f_wr_addr = '0; f_wr_data = '0;
        f_rd_en = 1'b0; f_rd_addr = '0;

        emit = 1'b0;
        res  = mk_res(KIND_ERROR, '0, 1'b0, '0, '0, 1'b0, dec_err);

        unique case (state_reg)
            ST_CLEAR: begin
                c_wr_en   = 1'b1;
                c_wr_addr = clr_reg;
                k_wr_en   = 1'b1;
                k_wr_addr = clr_reg[PAT_W-1:0];
                f_wr_en   = 1'b1;
                f_wr_addr = clr_reg[PAT_W-1:0];
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    op_next   = in_op;
                    byte_next = in_byte;
                    idx_next  = in_idx;
                end
            end
            ST_DECODE: begin
                if (dec_err != ERR_NONE) begin
                    emit = out_free;
                    // a close before build rewinds the insert point, even on error
                    if (out_free && op_reg == OP_CLOSE && !built_reg) begin
                        ins_node_next = '0;
                        ins_len_next  = '0;
                    end
                end else begin
                    case (op_reg)
                        OP_APPEND: begin
                            c_rd_en   = 1'b1;
                            c_rd_addr = {ins_node_reg, byte_reg};
                        end
                        OP_CLOSE: begin
                            emit = out_free;
                            if (ins_len_reg == '0) begin
                                res = mk_res(KIND_ACK, '0, 1'b0, '0, '0, 1'b0, ERR_NONE);
                            end else begin
                                res = mk_res(KIND_ACK, ID_W'(pat_used_reg[PAT_W-1:0]),
                                             1'b0, '0, '0, 1'b0, ERR_NONE);
                            end
                            if (out_free) begin
                                ins_node_next = '0;
                                ins_len_next  = '0;
                                if (ins_len_reg != '0) begin
                                    pat_used_next    = pat_used_reg + 1'b1;
                                    n_wr_en          = 1'b1;
                                    n_wr_addr        = ins_node_reg;
                                    n_wr_data.fail   = '0;
                                    n_wr_data.pvalid = 1'b1;
                                    n_wr_data.pid    = pat_used_reg[PAT_W-1:0];
                                    n_wr_data.term   = 1'b1;
                                end
                            end
                        end
                        OP_BUILD: begin
                            sym_next  = '0;
                            head_next = '0;
                            tail_next = '0;
                        end
                        OP_SCAN: begin
                            cur_next = scan_node_reg;
                        end
                        OP_END: begin
                            emit = out_free;
                            res  = mk_res(KIND_VERDICT, '0, 1'b0, '0,
                                          to_out(sat_inc(stream_reg)), any_found_reg,
                                          ERR_NONE);
                            if (out_free) begin
                                stream_next    = sat_inc(stream_reg);
                                any_found_next = 1'b0;
                                scan_node_next = '0;
                                clr_next       = '0;
                            end
                        end
                        OP_READ: begin
                            if (idx_ok) begin
                                k_rd_en   = 1'b1;
                                k_rd_addr = PAT_W'(idx_reg);
                            end else begin
                                emit = out_free;
                                res  = mk_res(KIND_READ, idx_reg, 1'b0, '0,
                                              to_out(stream_reg), 1'b0, ERR_NONE);
                            end
                        end
                        default: begin
                            emit = out_free;
                        end
                    endcase
                end
            end
            ST_INS_CK: begin
                emit = out_free;
                if (c_rd_data != '0) begin
                    res = mk_res(KIND_ACK, '0, 1'b0, '0, '0, 1'b0, ERR_NONE);
                    if (out_free) begin
                        ins_node_next = c_rd_data;
                        ins_len_next  = ins_len_reg + 1'b1;
                    end
                end else if (node_used_reg >= (NODE_W+1)'(MAX_NODES)) begin
                    res = mk_res(KIND_ERROR, '0, 1'b0, '0, '0, 1'b0, ERR_NODES);
                end else begin
                    res = mk_res(KIND_ACK, '0, 1'b0, '0, '0, 1'b0, ERR_NONE);
                    if (out_free) begin
                        c_wr_en        = 1'b1;
                        c_wr_addr      = {ins_node_reg, byte_reg};
                        c_wr_data      = node_used_reg[NODE_W-1:0];
                        n_wr_en        = 1'b1;
                        n_wr_addr      = node_used_reg[NODE_W-1:0];
                        node_used_next = node_used_reg + 1'b1;
                        ins_node_next  = node_used_reg[NODE_W-1:0];
                        ins_len_next   = ins_len_reg + 1'b1;
                    end
                end
            end
            ST_RD_OUT: begin
                emit = out_free;
                res  = mk_res(KIND_READ, idx_reg, 1'b0, to_out(k_rd_data),
                              to_out(stream_reg), 1'b0, ERR_NONE);
            end
            ST_SWEEP: begin
                f_wr_en   = 1'b1;
                f_wr_addr = clr_reg[PAT_W-1:0];
                clr_next  = clr_reg + 1'b1;
            end
            ST_BR_RD: begin
                c_rd_en   = 1'b1;
                c_rd_addr = {{NODE_W{1'b0}}, sym_reg};
            end
            ST_BR_CK: begin
                if (c_rd_data != '0) begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = tail_reg;
                    q_wr_data = c_rd_data;
                    tail_next = tail_reg + 1'b1;
                end
                sym_next = sym_reg + 1'b1;
            end
            ST_B_POP: begin
                if (head_reg != tail_reg) begin
                    q_rd_en   = 1'b1;
                    q_rd_addr = head_reg;
                    head_next = head_reg + 1'b1;
                end else begin
                    emit = out_free;
                    res  = mk_res(KIND_ACK, '0, 1'b0, '0, '0, 1'b0, ERR_NONE);
                    if (out_free) begin
                        built_next = 1'b1;
                    end
                end
            end
            ST_B_U: begin
                u_next    = q_rd_data;
                n_rd_en   = 1'b1;
                n_rd_addr = q_rd_data;
            end
            ST_B_UF: begin
                fu_next  = n_rd_data.fail;
                sym_next = '0;
            end
            ST_BV_RD: begin
                c_rd_en   = 1'b1;
                c_rd_addr = {u_reg, sym_reg};
            end
            ST_BV_CK: begin
                if (c_rd_data != '0) begin
                    v_next = c_rd_data;
                    f_next = fu_reg;
                end else begin
                    sym_next = sym_reg + 1'b1;
                end
            end
            ST_BF_RD: begin
                c_rd_en   = 1'b1;
                c_rd_addr = {f_reg, sym_reg};
            end
            ST_BF_CK: begin
                n_rd_en = 1'b1;
                if ((f_reg != '0) && (c_rd_data == '0)) begin
                    n_rd_addr = f_reg;
                end else begin
                    g_next    = c_rd_data;
                    n_rd_addr = c_rd_data;
                end
            end
            ST_BF_NX: begin
                f_next = n_rd_data.fail;
            end
            ST_B_G: begin
                // root carries no terminal mark
                tg_next   = (g_reg != '0) && n_rd_data.term;
                n_rd_en   = 1'b1;
                n_rd_addr = v_reg;
            end
            ST_B_VW: begin
                n_wr_en          = 1'b1;
                n_wr_addr        = v_reg;
                n_wr_data.fail   = g_reg;
                n_wr_data.pvalid = n_rd_data.pvalid;
                n_wr_data.pid    = n_rd_data.pid;
                n_wr_data.term   = n_rd_data.term | tg_reg;
                q_wr_en          = 1'b1;
                q_wr_addr        = tail_reg;
                q_wr_data        = v_reg;
                tail_next        = tail_reg + 1'b1;
                sym_next         = sym_reg + 1'b1;
            end
            ST_SC_RD: begin
                c_rd_en   = 1'b1;
                c_rd_addr = {cur_reg, byte_reg};
            end
            ST_SC_CK: begin
                if (walk_on) begin
                    n_rd_en   = 1'b1;
                    n_rd_addr = cur_reg;
                end else begin
                    scan_node_next = scan_hit;
                    cur_next       = scan_hit;
                    n_next         = '0;
                end
            end
            ST_SC_NX: begin
                cur_next = n_rd_data.fail;
            end
            ST_T_CHK: begin
                n_rd_en   = 1'b1;
                n_rd_addr = cur_reg;
            end
            ST_T_ND: begin
                if (n_rd_data.term && n_rd_data.pvalid) begin
                    k_rd_en    = 1'b1;
                    k_rd_addr  = n_rd_data.pid;
                    f_rd_en    = 1'b1;
                    f_rd_addr  = n_rd_data.pid;
                    id_next    = n_rd_data.pid;
                    nfail_next = n_rd_data.fail;
                end else if (n_rd_data.term) begin
                    cur_next = n_rd_data.fail;
                end
            end
            ST_T_CNT: begin
                // previous match goes out once a later one is known
                res      = pend_reg;
                res.last = 1'b0;
                emit     = pend_valid_reg && out_free;
                if (!pend_valid_reg || out_free) begin
                    k_wr_en         = 1'b1;
                    k_wr_addr       = id_reg;
                    k_wr_data       = hit_new;
                    f_wr_en         = 1'b1;
                    f_wr_addr       = id_reg;
                    f_wr_data       = 1'b1;
                    any_found_next  = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_next       = mk_res(KIND_MATCH, ID_W'(id_reg), ~f_rd_data[0],
                                             to_out(hit_new), '0, 1'b0, ERR_NONE);
                    n_next          = n_reg + 1'b1;
                    cur_next        = nfail_reg;
                end
            end
            ST_S_FIN: begin
                res  = pend_reg;
                emit = pend_valid_reg && out_free;
                if (out_free) begin
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_used_reg  <= (NODE_W+1)'(1);
            pat_used_reg   <= '0;
            ins_node_reg   <= '0;
            ins_len_reg    <= '0;
            scan_node_reg  <= '0;
            stream_reg     <= '0;
            any_found_reg  <= 1'b0;
            built_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            node_used_reg  <= node_used_next;
            pat_used_reg   <= pat_used_next;
            ins_node_reg   <= ins_node_next;
            ins_len_reg    <= ins_len_next;
            scan_node_reg  <= scan_node_next;
            stream_reg     <= stream_next;
            any_found_reg  <= any_found_next;
            built_reg      <= built_next;
            pend_valid_reg <= pend_valid_next;
            clr_reg        <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        byte_reg  <= byte_next;
        idx_reg   <= idx_next;
        sym_reg   <= sym_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        u_reg     <= u_next;
        fu_reg    <= fu_next;
        v_reg     <= v_next;
        f_reg     <= f_next;
        g_reg     <= g_next;
        tg_reg    <= tg_next;
        cur_reg   <= cur_next;
        nfail_reg <= nfail_next;
        id_reg    <= id_next;
        n_reg     <= n_next;
        pend_reg  <= pend_next;
    end

    assign stat.ready    = (state_reg == ST_IDLE);
    assign stat.clearing = (state_reg == ST_CLEAR);

endmodule

`default_nettype wire

[design/multi_pattern_byte_matcher.sv]
// Requests are taken only in the idle state, one at a time. Close, decode-error, end-of-stream,
// unknown-op and out-of-range read results load the output register from the decode state;
// append and count read first read a memory and go out from a check state. A scan's results
// come out one behind the chain walk, the last from the finish state. End of stream then sweeps
// the found set before the next request; a scan follows fail links, then walks the chain;
// build walks 256 child slots per node. Reset (aresetn low, synchronous): control cleared, then
// a pass zeroes child table, hit counters and found set; no request taken until done.
`default_nettype none

`include "multi_pattern_byte_matcher_macros.svh"

module multi_pattern_byte_matcher
    import mpbm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte, pattern_index, pad
    input  wire logic [OP_W-1:0]        s_tuser,   // op
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // pattern_id, first_in_stream,
                                                   // hit_count, stream_total,
                                                   // infected, error_code, pad
    output logic [2:0]                  m_tuser,   // kind
    output logic                        m_tlast
);

    logic       in_accept;
    logic       out_free;
    logic       ctl_emit;
    res_t       ctl_res;
    ctrl_stat_t stat;

    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg, out_res_next;

    assign in_accept = s_tvalid && s_tready;
    // output slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || m_tready;

    mpbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(in_accept),
        .in_op    (s_tuser),
        .in_byte  (s_tdata[SYM_W-1:0]),
        .in_idx   (s_tdata[SYM_W+ID_W-1:SYM_W]),
        .out_free (out_free),
        .emit     (ctl_emit),
        .res      (ctl_res),
        .stat     (stat)
    );

    // result register between the sequencer and the master port
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (ctl_emit) begin
            out_valid_next = 1'b1;
            out_res_next   = ctl_res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign s_tready = stat.ready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_res_reg.err, out_res_reg.inf,
                       out_res_reg.total, out_res_reg.hit, out_res_reg.first,
                       out_res_reg.pid};

    // sequencer only hands over a result when the register can take it
    `MPBM_ASSERT(a_emit_free, ctl_emit |-> out_free)
    `MPBM_ASSERT_NEXT(a_emit_loads, ctl_emit, m_tvalid)
    // no request taken while memories are being zeroed
    `MPBM_ASSERT(a_no_req_in_clear, stat.clearing |-> !s_tready)
    // only matches come in runs; every other kind closes its request
    `MPBM_ASSERT(a_single_last, (m_tvalid && (m_tuser != KIND_MATCH)) |-> m_tlast)

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import mpbm_pkg::*;

    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;
    localparam int LIMIT = 8000000;
    localparam int DRAIN = 5000;     // end of stream sweeps the found set
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    multi_pattern_byte_matcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // One request to the matcher; typed rows carry a hand-written answer.
    typedef struct {
        logic [2:0]  op;
        logic [7:0]  sym;
        logic [11:0] idx;
        bit          typed;
        res_t        want;
    } request_t;

    request_t requests[$];
    res_t     pending_results[$];   // results owed by the matcher, oldest first
    res_t     step_results[$];      // output of the shadow automaton for one request

    int fails = 0;
    int cycles = 0;
    int accepted = 0;
    int send_idle = 35;
    int recv_idle = 71;

    // ---------------- shadow automaton ----------------
    int unsigned   trie[int];       // node*256+sym -> child, absent = none
    logic [11:0]   fail_of[MAX_NODES];
    logic [12:0]   pat_of[MAX_NODES];    // bit 12: node ends a pattern
    bit            term_of[MAX_NODES];
    logic [31:0]   hits[MAX_PATTERN_COUNT];
    bit            seen[MAX_PATTERN_COUNT];
    int            nodes_used = 1;
    int            pats_used = 0;
    int            ins_node = 0;
    int            ins_len = 0;
    int            scan_at = 0;
    logic [31:0]   streams = '0;
    bit            any_seen = 0;
    bit            built = 0;

    initial begin
        foreach (fail_of[i]) begin
            fail_of[i] = '0;
            pat_of[i]  = '0;
            term_of[i] = 0;
        end
        foreach (hits[i]) begin
            hits[i] = '0;
            seen[i] = 0;
        end
    end

    function automatic int child_of(int node, int sym);
        int key;
        key = node * 256 + sym;
        return trie.exists(key) ? int'(trie[key]) : 0;
    endfunction

    function automatic void emit(kind_t k, int pid, bit first, logic [31:0] hit,
                                 logic [31:0] tot, bit inf, err_t e);
        res_t r;
        r.kind  = k;
        r.pid   = pid[11:0];
        r.first = first;
        r.hit   = hit;
        r.total = tot;
        r.inf   = inf;
        r.err   = e;
        r.last  = 1'b1;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void link_trie();
        int bfs[$];
        int u, v, f, g;
        for (int s = 0; s < 256; s++) begin
            v = child_of(0, s);
            if (v != 0) begin
                fail_of[v] = '0;
                bfs.insert(bfs.size(), v);
            end
        end
        while (bfs.size() != 0) begin
            u = bfs.pop_front();
            for (int s = 0; s < 256; s++) begin
                v = child_of(u, s);
                if (v != 0) begin
                    f = fail_of[u];
                    while (f != 0 && child_of(f, s) == 0)
                        f = fail_of[f];
                    g = child_of(f, s);
                    fail_of[v] = g[11:0];
                    term_of[v] = term_of[v] | term_of[g];
                    bfs.insert(bfs.size(), v);
                end
            end
        end
        built = 1;
    endfunction

    // Advances the shadow state by one request and leaves its results in step_results.
    function automatic void matcher_step(logic [2:0] op, logic [7:0] sym, logic [11:0] idx);
        int ch, cur, t, id, n;
        step_results.delete();
        case (op)
            OP_APPEND: begin
                if (built) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
                else if (ins_len >= MAX_PATTERN_LEN) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_LENGTH);
                else begin
                    ch = child_of(ins_node, sym);
                    if (ch == 0 && nodes_used >= MAX_NODES) begin
                        emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_NODES);
                    end else begin
                        if (ch == 0) begin
                            ch = nodes_used++;
                            fail_of[ch] = '0;
                            pat_of[ch]  = '0;
                            term_of[ch] = 0;
                            trie[ins_node * 256 + sym] = ch;
                        end
                        ins_node = ch;
                        ins_len++;
                        emit(KIND_ACK, 0, 0, 0, 0, 0, ERR_NONE);
                    end
                end
            end
            OP_CLOSE: begin
                if (built) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
                else begin
                    cur = ins_node;
                    n = ins_len;
                    ins_node = 0;
                    ins_len = 0;
                    if (n == 0) emit(KIND_ACK, 0, 0, 0, 0, 0, ERR_NONE);
                    else if (pats_used >= MAX_PATTERN_COUNT)
                        emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PATTERNS);
                    else begin
                        id = pats_used++;
                        term_of[cur] = 1;
                        pat_of[cur] = {1'b1, id[11:0]};
                        emit(KIND_ACK, id, 0, 0, 0, 0, ERR_NONE);
                    end
                end
            end
            OP_BUILD: begin
                if (built || ins_len != 0) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
                else begin
                    link_trie();
                    emit(KIND_ACK, 0, 0, 0, 0, 0, ERR_NONE);
                end
            end
            OP_SCAN: begin
                if (!built) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
                else begin
                    cur = scan_at;
                    while (cur != 0 && child_of(cur, sym) == 0)
                        cur = fail_of[cur];
                    ch = child_of(cur, sym);
                    if (ch != 0) cur = ch;
                    scan_at = cur;
                    t = cur;
                    n = 0;
                    // walk the output chain; each pattern on it is a hit
                    while (t != 0 && term_of[t] && n < RESULT_CAP) begin
                        if (pat_of[t][12]) begin
                            id = pat_of[t][11:0];
                            if (hits[id] != COUNT_TOP) hits[id] = hits[id] + 1;
                            emit(KIND_MATCH, id, !seen[id], hits[id], 0, 0, ERR_NONE);
                            step_results[n].last = 1'b0;
                            seen[id] = 1;
                            any_seen = 1;
                            n++;
                        end
                        t = fail_of[t];
                    end
                    if (n > 0) step_results[n-1].last = 1'b1;
                end
            end
            OP_END: begin
                if (!built) emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
                else begin
                    if (streams != COUNT_TOP) streams = streams + 1;
                    emit(KIND_VERDICT, 0, 0, 0, streams, any_seen, ERR_NONE);
                    foreach (seen[i]) seen[i] = 0;
                    any_seen = 0;
                    scan_at = 0;
                end
            end
            OP_READ: emit(KIND_READ, idx, 0, hits[idx], streams, 0, ERR_NONE);
            default: emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_PHASE);
        endcase
    endfunction

    // ---------------- stimulus construction ----------------
    function automatic void add(logic [2:0] op, logic [7:0] sym, logic [11:0] idx);
        request_t q;
        q.op = op;
        q.sym = sym;
        q.idx = idx;
        q.typed = 0;
        q.want = '0;
        requests.insert(requests.size(), q);
    endfunction

    function automatic void add_known(logic [2:0] op, logic [7:0] sym, logic [11:0] idx,
                                      kind_t k, logic [11:0] pid, err_t e);
        request_t q;
        q.op = op;
        q.sym = sym;
        q.idx = idx;
        q.typed = 1;
        q.want = '0;
        q.want.kind = k;
        q.want.pid = pid;
        q.want.err = e;
        q.want.last = 1'b1;
        requests.insert(requests.size(), q);
    endfunction

    // mostly a narrow alphabet so the patterns overlap and the stream hits them
    function automatic logic [7:0] pick_sym();
        return ($urandom_range(99) < 85) ? 8'($urandom_range(8'h64, 8'h61))
                                         : 8'($urandom_range(255));
    endfunction

    function automatic void make_requests();
        int len;
        // directed: wrong phase, reads after reset, unknown ops, pattern basics
        add_known(OP_SCAN,  8'h61, 12'd0,    KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_END,   8'h00, 12'd0,    KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_BAD6,  8'h00, 12'd0,    KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_BAD7,  8'hFF, 12'hFFF,  KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_READ,  8'h00, 12'd0,    KIND_READ,  12'd0, ERR_NONE);
        add_known(OP_READ,  8'hFF, 12'hFFF,  KIND_READ,  12'hFFF, ERR_NONE);
        add_known(OP_CLOSE, 8'h00, 12'd0,    KIND_ACK,   12'd0, ERR_NONE);  // empty close
        add_known(OP_APPEND, 8'h61, 12'd0,   KIND_ACK,   12'd0, ERR_NONE);
        add_known(OP_APPEND, 8'h62, 12'd0,   KIND_ACK,   12'd0, ERR_NONE);
        add_known(OP_BUILD, 8'h00, 12'd0,    KIND_ERROR, 12'd0, ERR_PHASE); // pattern open
        add_known(OP_CLOSE, 8'h00, 12'd0,    KIND_ACK,   12'd0, ERR_NONE);  // id 0: "ab"
        add_known(OP_APPEND, 8'h00, 12'd0,   KIND_ACK,   12'd0, ERR_NONE);
        add_known(OP_APPEND, 8'hFF, 12'd0,   KIND_ACK,   12'd0, ERR_NONE);
        add_known(OP_CLOSE, 8'h00, 12'd0,    KIND_ACK,   12'd1, ERR_NONE);
        add(OP_APPEND, 8'h62, 0);
        add(OP_CLOSE, 0, 0);                 // "b", suffix of "ab"
        add(OP_APPEND, 8'h61, 0);
        add(OP_APPEND, 8'h62, 0);
        add(OP_CLOSE, 0, 0);                 // "ab" again takes the newer id
        // one overlong pattern: the bytes past the limit are refused
        for (int i = 0; i < MAX_PATTERN_LEN + 3; i++) add(OP_APPEND, pick_sym(), 0);
        add(OP_CLOSE, 0, 0);
        // random patterns, short, mostly over the narrow alphabet
        for (int p = 0; p < 24; p++) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
            for (int i = 0; i < len; i++) add(OP_APPEND, pick_sym(), 0);
            add(OP_CLOSE, 0, 0);
        end
        add(OP_BUILD, 0, 0);
        add_known(OP_APPEND, 8'h61, 12'd0, KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_CLOSE,  8'h00, 12'd0, KIND_ERROR, 12'd0, ERR_PHASE);
        add_known(OP_BUILD,  8'h00, 12'd0, KIND_ERROR, 12'd0, ERR_PHASE);
        // random stream traffic
        for (int i = 0; i < 120; i++) begin
            case ($urandom_range(99)) inside
                [0:81]:  add(OP_SCAN, pick_sym(), 12'($urandom_range(4095)));
                [82:88]: add(OP_END, 8'($urandom_range(255)), 12'($urandom_range(4095)));
                [89:95]: add(OP_READ, 8'($urandom_range(255)), 12'($urandom_range(40)));
                default: add(OP_READ, 8'($urandom_range(255)), 12'($urandom_range(4095)));
            endcase
        end
        add(OP_END, 0, 0);
        for (int i = 0; i < 20; i++) add(OP_READ, 0, 12'(i));
    endfunction

    // ---------------- sender ----------------
    initial begin
        request_t q;
        make_requests();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        foreach (requests[i]) begin
            // idling switches over after each third of the run
            if (i == requests.size() / 3) begin
                send_idle = 71;
                recv_idle = 35;
            end else if (i == 2 * requests.size() / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            while ($urandom_range(99) < send_idle) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            q = requests[i];
            s_tvalid = 1'b1;
            s_tdata = {4'b0, q.idx, q.sym};
            s_tuser = q.op;
            do @(posedge aclk); while (!s_tready);
            accepted++;
            matcher_step(q.op, q.sym, q.idx);
            if (q.typed) pending_results.insert(pending_results.size(), q.want);
            else foreach (step_results[j])
                pending_results.insert(pending_results.size(), step_results[j]);
            @(negedge aclk);
        end
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ---------------- receiver and checker ----------------
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        res_t want;
        logic [11:0] pid;
        logic        first, inf;
        logic [31:0] hit, tot;
        logic [2:0]  err;
        if (aresetn && m_tvalid && m_tready) begin
            pid   = m_tdata[11:0];
            first = m_tdata[12];
            hit   = m_tdata[44:13];
            tot   = m_tdata[76:45];
            inf   = m_tdata[77];
            err   = m_tdata[80:78];
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result kind=%0d pid=%0d", m_tuser, pid);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.kind || pid != want.pid || first != want.first ||
                    hit != want.hit || tot != want.total || inf != want.inf ||
                    err != want.err || m_tlast != want.last) begin
                    fails++;
                    if (fails <= 10)
                        $display({"mismatch: exp kind=%0d pid=%0d first=%0d hit=%0d tot=%0d ",
                                  "inf=%0d err=%0d last=%0d / got %0d %0d %0d %0d %0d %0d ",
                                  "%0d %0d"},
                                 want.kind, want.pid, want.first, want.hit, want.total,
                                 want.inf, want.err, want.last, m_tuser, pid, first, hit,
                                 tot, inf, err, m_tlast);
                end
            end
        end
    end

    // watchdog; the reset clearing pass alone covers the whole child table
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

`default_nettype wire
